// ----- rtl/core/cpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants
// Command and status codes, register indexes and the memory control bundle
// of the checked pool allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int HANDLE_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MASK_W = 4;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_DOUBLE_FREE = 3'd1,
    STS_NEVER_ISSUED = 3'd2,
    STS_NULL_FREE   = 3'd3,
    STS_EXHAUSTED   = 3'd4
  } status_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MASK = 2'd1;

  // report_mask bit positions
  localparam int MSK_DOUBLE_FREE = 0;
  localparam int MSK_NEVER_ISSUED = 1;
  localparam int MSK_NULL_FREE = 2;
  localparam int MSK_EXHAUSTED = 3;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  // control toward the link/tag memories
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic tag_we;
    logic tag_wdata;
  } mem_ctl_t;

endpackage

// ----- rtl/core/cpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_cmd_if / cpa_rsp_if: command and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cpa_cmd_if;
  import cpa_pkg::*;

  logic    valid;
  logic    ready;
  cmd_t    command;
  handle_t handle_in;

  modport source (output valid, output command, output handle_in, input ready);
  modport sink   (input valid, input command, input handle_in, output ready);
endinterface

interface cpa_rsp_if;
  import cpa_pkg::*;

  logic    valid;
  logic    ready;
  handle_t handle_out;
  status_t status;
  logic    error_flag;
  handle_t in_use_count;

  modport source (output valid, output handle_out, output status, output error_flag,
                  output in_use_count, input ready);
  modport sink   (input valid, input handle_out, input status, input error_flag,
                  input in_use_count, output ready);
endinterface

// ----- rtl/core/cpa_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_store: free-list link and issued-tag memories
// Two single-port-write, single-port-read arrays sharing addresses, with a
// registered read. No reset; the read data of an entry is only used once that
// entry has been written.
// ----------------------------------------------------------------------------
module cpa_store #(
  parameter int POOL_SIZE = 1024,
  parameter int AW = 10
) (
  input  logic                clk,
  input  cpa_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  cpa_pkg::handle_t    link_wdata,
  output cpa_pkg::handle_t    link_rdata,
  output logic                tag_rdata
);
  import cpa_pkg::*;

  handle_t link_mem [POOL_SIZE];
  logic    tag_mem  [POOL_SIZE];
  handle_t link_rdata_r;
  logic    tag_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (ctl.rd_en) begin
      link_rdata_r <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[wr_addr] <= ctl.tag_wdata;
    end
    if (ctl.rd_en) begin
      tag_rdata_r <= tag_mem[rd_addr];
    end
  end

  assign link_rdata = link_rdata_r;
  assign tag_rdata  = tag_rdata_r;

endmodule

// ----- rtl/core/cpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_ctrl: command sequencer and checker
// Issues the memory read on accept, then checks, updates the free list and
// counters, writes back and loads the response register.
// ----------------------------------------------------------------------------
module cpa_ctrl #(
  parameter int POOL_SIZE = 1024,
  parameter int AW = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cpa_cmd_if.sink                       in_cmd,
  cpa_rsp_if.source                     out_rsp,
  input  logic                          cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cpa_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 mem_rd_addr,
  output logic [AW-1:0]                 mem_wr_addr,
  output cpa_pkg::handle_t              link_wdata,
  input  cpa_pkg::handle_t              link_rdata,
  input  logic                          tag_rdata
);
  import cpa_pkg::*;

  localparam int IW = (AW > HANDLE_W) ? AW : HANDLE_W;
  localparam int CW = 17;
  localparam logic [CW-1:0] POOL_W = CW'(POOL_SIZE);

  // handle 1..N maps to entry 0..N-1
  function automatic logic [AW-1:0] entry_of(input handle_t h);
    logic [IW-1:0] wide;
    wide = IW'(h) - IW'(1);
    return wide[AW-1:0];
  endfunction

  fsm_t    state_r, state_nxt;
  cmd_t    cmd_r;
  handle_t hdl_r;
  handle_t free_head_r, free_head_nxt;
  handle_t next_fresh_r, next_fresh_nxt;
  handle_t live_r, live_nxt;
  handle_t pool_limit_r;
  logic [MASK_W-1:0] report_mask_r;

  logic    out_valid_r;
  handle_t out_handle_r;
  status_t out_status_r;
  logic    out_err_r;
  handle_t out_count_r;

  logic    in_fire;
  logic    out_room;
  logic    commit;
  handle_t res_handle;
  status_t res_status;
  logic    res_err;
  handle_t fresh_inc;
  logic [CW-1:0] eff_limit;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_cmd.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_room) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    in_cmd.ready = 1'b0;
    commit       = 1'b0;
    case (state_r)
      S_IDLE:  in_cmd.ready = 1'b1;
      S_EXEC:  commit = out_room;
      default: begin
        in_cmd.ready = 1'b0;
        commit       = 1'b0;
      end
    endcase
  end

  assign in_fire  = in_cmd.valid && in_cmd.ready;
  assign out_room = !out_valid_r || out_rsp.ready;

  assign eff_limit = (CW'(pool_limit_r) < POOL_W) ? CW'(pool_limit_r) : POOL_W;
  assign fresh_inc = next_fresh_r + HANDLE_W'(1);

  // read address: tag of the freed handle, or link of the list head
  assign mem_rd_addr = (in_cmd.command == CMD_FREE) ? entry_of(in_cmd.handle_in)
                                                    : entry_of(free_head_r);

  // ---------------- check and update ----------------
  always_comb begin
    mem_ctl         = '0;
    mem_ctl.rd_en   = in_fire;
    mem_wr_addr     = entry_of(hdl_r);
    link_wdata      = free_head_r;
    res_handle      = '0;
    res_status      = STS_OK;
    free_head_nxt   = free_head_r;
    next_fresh_nxt  = next_fresh_r;
    live_nxt        = live_r;

    if (cmd_r == CMD_ALLOC) begin
      if (free_head_r != '0 && CW'(free_head_r) <= POOL_W) begin
        res_handle        = free_head_r;
        free_head_nxt     = link_rdata;
        mem_wr_addr       = entry_of(free_head_r);
        mem_ctl.tag_we    = commit;
        mem_ctl.tag_wdata = 1'b1;
        live_nxt          = live_r + HANDLE_W'(1);
      end else if (CW'(next_fresh_r) < eff_limit) begin
        next_fresh_nxt    = fresh_inc;
        res_handle        = fresh_inc;
        mem_wr_addr       = entry_of(fresh_inc);
        mem_ctl.tag_we    = commit;
        mem_ctl.tag_wdata = 1'b1;
        live_nxt          = live_r + HANDLE_W'(1);
      end else begin
        res_status = STS_EXHAUSTED;
      end
    end else begin
      if (hdl_r == '0) begin
        res_status = STS_NULL_FREE;
      end else if (hdl_r > next_fresh_r || CW'(hdl_r) > POOL_W) begin
        res_status = STS_NEVER_ISSUED;
      end else if (!tag_rdata) begin
        res_status = STS_DOUBLE_FREE;
      end else begin
        mem_ctl.tag_we    = commit;
        mem_ctl.tag_wdata = 1'b0;
        mem_ctl.link_we   = commit;
        free_head_nxt     = hdl_r;
        live_nxt          = live_r - HANDLE_W'(1);
      end
    end
  end

  always_comb begin
    case (res_status)
      STS_DOUBLE_FREE:  res_err = !report_mask_r[MSK_DOUBLE_FREE];
      STS_NEVER_ISSUED: res_err = !report_mask_r[MSK_NEVER_ISSUED];
      STS_NULL_FREE:    res_err = !report_mask_r[MSK_NULL_FREE];
      STS_EXHAUSTED:    res_err = !report_mask_r[MSK_EXHAUSTED];
      default:          res_err = 1'b0;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      free_head_r   <= '0;
      next_fresh_r  <= '0;
      live_r        <= '0;
      pool_limit_r  <= HANDLE_W'(1024);
      report_mask_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        free_head_r  <= free_head_nxt;
        next_fresh_r <= next_fresh_nxt;
        live_r       <= live_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_LIMIT:  pool_limit_r  <= cfg_wdata;
          CFG_REPORT_MASK: report_mask_r <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_cmd.command;
      hdl_r <= in_cmd.handle_in;
    end
    if (commit) begin
      out_handle_r <= res_handle;
      out_status_r <= res_status;
      out_err_r    <= res_err;
      out_count_r  <= live_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.handle_out   = out_handle_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.error_flag   = out_err_r;
  assign out_rsp.in_use_count = out_count_r;

  // ---------------- assertions ----------------
  a_live_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= next_fresh_r)
    else $error("live count above issued count");

  a_head_issued: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= next_fresh_r)
    else $error("free list head was never issued");

  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_handle_r != '0) |-> (out_status_r == STS_OK))
    else $error("handle returned with error status");

  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_status_r != STS_OK))
    else $error("error flag without error status");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted command not executed");

endmodule

// ----- rtl/core/checked_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checked_pool_allocator: fixed-size pool allocator with checked frees
// LIFO free list kept as links in memory, bump pointer for fresh handles,
// per-handle issued tag for double-free and bad-handle detection.
//
//   channel   dir   handshake      payload
//   in_cmd    in    valid/ready    command, handle_in
//   out_rsp   out   valid/ready    handle_out, status, error_flag, in_use_count
//   cfg_*     in    write enable   cfg_index, cfg_wdata (no read-back)
//
// Each command runs as accept + memory read in S_IDLE, then check/write-back in S_EXEC.
// The registered read of the link/tag memories sets this split.
// Reset is synchronous; memories need no clearing pass.
// A held response stalls only the check cycle of the following command.
// ----------------------------------------------------------------------------
module checked_pool_allocator #(
  parameter int POOL_SIZE = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpa_cmd_if.sink                        in_cmd,
  cpa_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cpa_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_rd_addr;
  logic [AW-1:0] mem_wr_addr;
  handle_t       link_wdata;
  handle_t       link_rdata;
  logic          tag_rdata;

  cpa_ctrl #(
    .POOL_SIZE (POOL_SIZE),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_cmd),
    .out_rsp     (out_rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .link_wdata  (link_wdata),
    .link_rdata  (link_rdata),
    .tag_rdata   (tag_rdata)
  );

  cpa_store #(
    .POOL_SIZE (POOL_SIZE),
    .AW        (AW)
  ) u_store (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (mem_rd_addr),
    .wr_addr    (mem_wr_addr),
    .link_wdata (link_wdata),
    .link_rdata (link_rdata),
    .tag_rdata  (tag_rdata)
  );

endmodule
